@@ rtl/agarch_variance_recursion_top_defines.svh @@
// ----------------------------------------------------------------------------
// agarch_variance_recursion_top_defines
// Assertion macros for the checker file of the variance recursion block.
// ----------------------------------------------------------------------------
`ifndef AGARCH_VARIANCE_RECURSION_TOP_DEFINES_SVH
`define AGARCH_VARIANCE_RECURSION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define AGV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("agv assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define AGV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("agv assertion failed");

`endif

@@ rtl/agv_pkg.sv @@
// ----------------------------------------------------------------------------
// agv_pkg
// Shared constants and codes of the asymmetric GARCH variance recursion block.
// ----------------------------------------------------------------------------
package agv_pkg;

  localparam int unsigned LAG_SLOTS = 4;
  localparam int unsigned IDX_W     = $clog2(LAG_SLOTS);
  localparam int unsigned ORD_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    REQ_LOAD_ALPHA = 2'd0,
    REQ_LOAD_BETA  = 2'd1,
    REQ_RESIDUAL   = 2'd2,
    REQ_NONE       = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OMEGA      = 3'd1,
    ST_NEG_ALPHA  = 3'd2,
    ST_NEG_BETA   = 3'd3,
    ST_NOT_STAT   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OMEGA     = 3'd0,
    CFG_ASYMMETRY = 3'd1,
    CFG_BACKCAST  = 3'd2,
    CFG_ARCH      = 3'd3,
    CFG_GARCH     = 3'd4
  } cfg_e;

endpackage

@@ rtl/agarch_variance_recursion_top.sv @@
// ----------------------------------------------------------------------------
// agarch_variance_recursion_top
// Streams residuals and returns the asymmetric GARCH conditional variance.
// ----------------------------------------------------------------------------
// A coefficient load returns no beat. A residual beat runs the full
// recursion over as many lags as the larger of the ARCH and GARCH orders
// in use; the bit-serial square root, one result bit per cycle for each
// ARCH lag, is its longest step. Backcast and failed-validation samples
// skip the recursion. A result beat that is held back keeps the next one
// waiting in the done state. Lag history lives in a four-entry memory
// read one entry at a time, and one shared multiplier does all products.
// A finished result waits in an output register while the next beat is
// taken.
module agarch_variance_recursion_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [1:0]                    coef_index_i,
  input  logic signed [31:0]            coef_value_i,
  input  logic signed [31:0]            residual_i,
  input  logic                          series_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   cond_variance_o,
  output logic [2:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic [agv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import agv_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CHECK = 13'b0000000000010,
    S_READ  = 13'b0000000000100,
    S_LOAD  = 13'b0000000001000,
    S_SQRT  = 13'b0000000010000,
    S_MGR   = 13'b0000000100000,
    S_SHOCK = 13'b0000001000000,
    S_MSQ   = 13'b0000010000000,
    S_AHI   = 13'b0000100000000,
    S_ALO   = 13'b0001000000000,
    S_BLO   = 13'b0010000000000,
    S_ACC   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]      omega_q, asym_q, backcast_q;
  logic [ORD_W-1:0] arch_q, garch_q;
  logic [31:0]      alpha_q [LAG_SLOTS];
  logic [31:0]      beta_q  [LAG_SLOTS];
  logic [63:0]      hist_mem [LAG_SLOTS];
  logic [63:0]      rdata_q;
  logic [IDX_W-1:0] wp_q;
  logic [ORD_W-1:0] count_q;
  logic [ORD_W-1:0] j_q;
  logic             beta_ph_q;
  logic [31:0]      e_q;
  logic [44:0]      acc_q, acc_d;
  logic [55:0]      x_q;
  logic [29:0]      rem_q;
  logic [27:0]      root_q;
  logic [4:0]       it_q;
  logic [32:0]      smag_q;
  logic [31:0]      sqlo_q;
  logic [41:0]      ph_q;
  logic [65:0]      prod_q;
  logic [31:0]      fin_h_q;
  logic [2:0]       fin_st_q;
  logic             push_q;
  logic             out_valid_q;

  logic [ORD_W-1:0] p, q, m;
  logic [2:0]       status;
  logic [IDX_W-1:0] jx, raddr;
  logic [32:0]      mul_a, mul_b;
  logic [31:0]      gmag, gr;
  logic signed [33:0] gs, shock;
  logic [31:0]      rem_tmp, trial;
  logic [40:0]      r_sum, term;
  logic [31:0]      acc_sat, omega_sat;
  logic             accept, out_free;

  assign p = (arch_q > ORD_W'(LAG_SLOTS)) ? ORD_W'(LAG_SLOTS) : arch_q;
  assign q = (garch_q > ORD_W'(LAG_SLOTS)) ? ORD_W'(LAG_SLOTS) : garch_q;
  assign m = (p > q) ? p : q;
  assign jx = j_q[IDX_W-1:0];
  assign raddr = wp_q - IDX_W'(1) - jx;

  always_comb begin
    logic [34:0] sum;
    logic        neg_a, neg_b;
    sum = '0;
    neg_a = 1'b0;
    neg_b = 1'b0;
    for (int k = 0; k < LAG_SLOTS; k++) begin
      if (ORD_W'(k) < p) begin
        neg_a = neg_a | alpha_q[k][31];
        sum = sum + 35'(alpha_q[k]);
      end
      if (ORD_W'(k) < q) begin
        neg_b = neg_b | beta_q[k][31];
        sum = sum + 35'(beta_q[k]);
      end
    end
    if (omega_q[31] || omega_q == '0) begin
      status = ST_OMEGA;
    end else if (neg_a) begin
      status = ST_NEG_ALPHA;
    end else if (neg_b) begin
      status = ST_NEG_BETA;
    end else if (sum >= 35'(1 << 28)) begin
      status = ST_NOT_STAT;
    end else begin
      status = ST_OK;
    end
  end

  assign gmag = asym_q[31] ? (32'd0 - asym_q) : asym_q;
  assign gr = prod_q[59:28];
  assign gs = asym_q[31] ? -$signed({2'b00, gr}) : $signed({2'b00, gr});
  assign shock = $signed({{2{rdata_q[63]}}, rdata_q[63:32]}) - gs;

  assign rem_tmp = {rem_q, x_q[55:54]};
  assign trial = {2'b00, root_q, 2'b01};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MGR: begin
        mul_a = {1'b0, gmag};
        mul_b = {5'b0, root_q};
      end
      S_MSQ: begin
        mul_a = smag_q;
        mul_b = smag_q;
      end
      S_AHI: begin
        mul_a = {1'b0, alpha_q[jx]};
        mul_b = {23'b0, prod_q[65:56]};
      end
      S_ALO: begin
        mul_a = {1'b0, alpha_q[jx]};
        mul_b = {1'b0, sqlo_q};
      end
      S_BLO: begin
        mul_a = {1'b0, beta_q[jx]};
        mul_b = {1'b0, rdata_q[31:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign r_sum = {1'b0, ph_q[35:0], 4'b0} + 41'(prod_q[63:28]);
  assign term = (ph_q[41:36] != '0 || r_sum > 41'(64'd1 << 40)) ? 41'(64'd1 << 40) : r_sum;
  assign acc_d = acc_q + 45'(term);
  assign acc_sat = (acc_d > 45'(32'hFFFFFFFF)) ? 32'hFFFFFFFF :
                   (acc_d == '0) ? 32'd1 : acc_d[31:0];
  assign omega_sat = omega_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && req_type_i == REQ_RESIDUAL) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status != ST_OK || count_q < m || m == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = (j_q < p) ? S_SQRT : S_BLO;
      S_SQRT:  state_d = (it_q == 5'd27) ? S_MGR : S_SQRT;
      S_MGR:   state_d = S_SHOCK;
      S_SHOCK: state_d = S_MSQ;
      S_MSQ:   state_d = S_AHI;
      S_AHI:   state_d = S_ALO;
      S_ALO:   state_d = S_ACC;
      S_BLO:   state_d = S_ACC;
      S_ACC: begin
        if (!beta_ph_q && j_q < q) begin
          state_d = S_BLO;
        end else if (j_q + ORD_W'(1) < m) begin
          state_d = S_READ;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      omega_q     <= '0;
      asym_q      <= '0;
      backcast_q  <= '0;
      arch_q      <= ORD_W'(1);
      garch_q     <= ORD_W'(1);
      for (int k = 0; k < LAG_SLOTS; k++) begin
        alpha_q[k] <= '0;
        beta_q[k]  <= '0;
      end
      wp_q        <= '0;
      count_q     <= '0;
      j_q         <= '0;
      beta_ph_q   <= 1'b0;
      it_q        <= '0;
      push_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OMEGA:     omega_q    <= cfg_data_i;
          CFG_ASYMMETRY: asym_q     <= cfg_data_i;
          CFG_BACKCAST:  backcast_q <= cfg_data_i;
          CFG_ARCH:      arch_q     <= cfg_data_i[ORD_W-1:0];
          CFG_GARCH:     garch_q    <= cfg_data_i[ORD_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_LOAD_ALPHA: alpha_q[coef_index_i[IDX_W-1:0]] <= coef_value_i;
              REQ_LOAD_BETA:  beta_q[coef_index_i[IDX_W-1:0]]  <= coef_value_i;
              REQ_RESIDUAL: begin
                if (series_start_i) begin
                  count_q <= '0;
                end
              end
              default: begin
              end
            endcase
          end
          j_q <= '0;
          beta_ph_q <= 1'b0;
        end
        S_CHECK: begin
          push_q <= (status == ST_OK);
        end
        S_LOAD: begin
          it_q <= '0;
          if (j_q >= p) begin
            beta_ph_q <= 1'b1;
          end
        end
        S_SQRT: it_q <= it_q + 5'd1;
        S_BLO:  beta_ph_q <= 1'b1;
        S_ACC: begin
          if (beta_ph_q || j_q >= q) begin
            beta_ph_q <= 1'b0;
            j_q <= j_q + ORD_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (push_q) begin
              wp_q <= wp_q + IDX_W'(1);
              if (count_q < ORD_W'(LAG_SLOTS)) begin
                count_q <= count_q + ORD_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        e_q <= residual_i;
      end
      S_CHECK: begin
        acc_q <= {13'b0, omega_q};
        if (status != ST_OK) begin
          fin_h_q  <= '0;
          fin_st_q <= status;
        end else if (count_q < m) begin
          fin_h_q  <= backcast_q;
          fin_st_q <= ST_OK;
        end else begin
          fin_h_q  <= omega_sat;
          fin_st_q <= ST_OK;
        end
      end
      S_READ: rdata_q <= hist_mem[raddr];
      S_LOAD: begin
        x_q    <= {rdata_q[31:0], 24'b0};
        rem_q  <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        x_q <= {x_q[53:0], 2'b00};
        if (rem_tmp >= trial) begin
          rem_q  <= 30'(rem_tmp - trial);
          root_q <= {root_q[26:0], 1'b1};
        end else begin
          rem_q  <= rem_tmp[29:0];
          root_q <= {root_q[26:0], 1'b0};
        end
      end
      S_SHOCK: smag_q <= shock[33] ? 33'(-shock) : 33'(shock);
      S_AHI:   sqlo_q <= prod_q[55:24];
      S_ALO:   ph_q   <= prod_q[41:0];
      S_BLO:   ph_q   <= '0;
      S_ACC: begin
        acc_q   <= acc_d;
        fin_h_q <= acc_sat;
      end
      S_DONE: begin
        if (out_free) begin
          cond_variance_o <= fin_h_q;
          status_o        <= fin_st_q;
          if (push_q) begin
            hist_mem[wp_q] <= {e_q, fin_h_q};
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/agv_checker.sv @@
// ----------------------------------------------------------------------------
// agv_checker
// Port-level checks of the variance recursion block, bound to its top level.
// ----------------------------------------------------------------------------
`include "agarch_variance_recursion_top_defines.svh"

module agv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  req_type_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] cond_variance_o,
  input logic [2:0]  status_o
);
  import agv_pkg::*;

  `AGV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o))
  `AGV_ASSERT_NOW(a_fail_zero, out_valid_o && status_o != ST_OK, cond_variance_o == '0)
  `AGV_ASSERT_NOW(a_status_range, out_valid_o, status_o <= ST_NOT_STAT)
  `AGV_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o && req_type_i == REQ_RESIDUAL, !in_ready_o)

endmodule

bind agarch_variance_recursion_top agv_checker u_agv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .req_type_i      (req_type_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .cond_variance_o (cond_variance_o),
  .status_o        (status_o)
);
